>>> rtl/core/flex_gesture_track_trigger_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef FLEX_GESTURE_TRACK_TRIGGER_UNIT_ASSERT_SVH
`define FLEX_GESTURE_TRACK_TRIGGER_UNIT_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define FGTT_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("check failed");

// Same-cycle implication.
`define FGTT_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("check failed");

// Next-cycle implication.
`define FGTT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("check failed");

`endif

>>> rtl/core/fgtt_pkg.sv
// Types, constants and frame byte function of the gesture track trigger.
package fgtt_pkg;

	localparam int FGTT_FINGERS   = 5;
	localparam int FGTT_FRAME_LEN = 10;
	localparam int FGTT_SAMPLE_W  = 12;
	localparam int FGTT_WIN_W     = 24;
	localparam int FGTT_REG_IDX_W = 3;

	typedef logic [FGTT_SAMPLE_W-1:0] fgtt_avg_t;
	typedef logic [FGTT_WIN_W-1:0]    fgtt_win_t;
	typedef logic [2:0]               fgtt_track_t;
	typedef logic [3:0]               fgtt_pos_t;

	// register indexes
	localparam logic [FGTT_REG_IDX_W-1:0] FGTT_REG_THUMB  = 3'd0;
	localparam logic [FGTT_REG_IDX_W-1:0] FGTT_REG_PINKY  = 3'd4;

	localparam fgtt_win_t FGTT_WIN_RESET [FGTT_FINGERS] = '{
		24'h5E75BE, 24'h5D05AA, 24'h7216EA, 24'h6D16AE, 24'h5EB5AF
	};

	// finger slot checked at each priority step; track = step + 1
	localparam logic [2:0] FGTT_PRIO [FGTT_FINGERS] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd4};

	localparam logic [7:0] FGTT_START_BYTE = 8'h7E;
	localparam logic [7:0] FGTT_VER_BYTE   = 8'hFF;
	localparam logic [7:0] FGTT_LEN_BYTE   = 8'h06;
	localparam logic [7:0] FGTT_CMD_PLAY   = 8'h03;
	localparam logic [7:0] FGTT_ZERO_BYTE  = 8'h00;
	localparam logic [7:0] FGTT_END_BYTE   = 8'hEF;

	localparam fgtt_pos_t FGTT_LAST_POS = 4'(FGTT_FRAME_LEN - 1);

	typedef struct packed {
		logic        start;
		fgtt_track_t track;
	} fgtt_play_t;

	function automatic logic [7:0] fgtt_frame_byte(fgtt_pos_t pos, fgtt_track_t track);
		logic [15:0] cks;
		logic [7:0]  b;
		cks = 16'd0 - (16'(FGTT_VER_BYTE) + 16'(FGTT_LEN_BYTE) + 16'(FGTT_CMD_PLAY)
			+ 16'(track));
		unique case (pos)
			4'd0:    b = FGTT_START_BYTE;
			4'd1:    b = FGTT_VER_BYTE;
			4'd2:    b = FGTT_LEN_BYTE;
			4'd3:    b = FGTT_CMD_PLAY;
			4'd4:    b = FGTT_ZERO_BYTE;
			4'd5:    b = FGTT_ZERO_BYTE;
			4'd6:    b = 8'(track);
			4'd7:    b = cks[15:8];
			4'd8:    b = cks[7:0];
			default: b = FGTT_END_BYTE;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/fgtt_average.sv
// Round position, per-finger accumulation and reciprocal-multiply averaging.
module fgtt_average import fgtt_pkg::*; #(
	parameter int SAMPLES = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_acc,
	input  logic [FGTT_SAMPLE_W-1:0]          sample,
	output fgtt_avg_t [FGTT_FINGERS-1:0]      avg,
	output logic                              eval,
	output logic                              pending,
	output logic                              next_rend
);

	localparam int SUM_W   = $clog2(SAMPLES * 4095 + 1);
	localparam int SHIFT   = SUM_W + 5;
	localparam int MULT_W  = SHIFT + 1;
	localparam int PROD_W  = SUM_W + MULT_W;
	localparam int CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam logic [MULT_W-1:0] MULT = MULT_W'(((1 << SHIFT) + SAMPLES - 1) / SAMPLES);

	logic [CNT_W-1:0]         cnt_q;
	logic [2:0]               finger_q;
	logic                     last, rend;

	logic [FGTT_SAMPLE_W-1:0] sample_s1;
	logic                     valid_s1, last_s1, rend_s1;
	logic [2:0]               finger_s1;

	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         total;

	logic [PROD_W-1:0]        prod_s2;
	logic                     wr_s2, rend_s2;
	logic [2:0]               finger_s2;

	logic                     eval_s3;
	fgtt_avg_t                avg_q [FGTT_FINGERS];

	assign last      = (cnt_q == CNT_W'(SAMPLES - 1));
	assign rend      = last && (finger_q == 3'(FGTT_FINGERS - 1));
	assign next_rend = rend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			finger_q <= '0;
		end else if (in_acc) begin
			if (last) begin
				cnt_q    <= '0;
				finger_q <= rend ? 3'd0 : finger_q + 3'd1;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			rend_s1  <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			last_s1  <= in_acc && last;
			rend_s1  <= in_acc && rend;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
			finger_s1 <= finger_q;
		end
	end

	assign total = sum_q + SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (valid_s1) begin
			sum_q <= last_s1 ? '0 : total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2   <= 1'b0;
			rend_s2 <= 1'b0;
			eval_s3 <= 1'b0;
		end else begin
			wr_s2   <= valid_s1 && last_s1;
			rend_s2 <= valid_s1 && rend_s1;
			eval_s3 <= wr_s2 && rend_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			prod_s2   <= PROD_W'(total) * PROD_W'(MULT);
			finger_s2 <= finger_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s2)
			avg_q[finger_s2] <= prod_s2[SHIFT +: FGTT_SAMPLE_W];
	end

	always_comb begin
		for (int i = 0; i < FGTT_FINGERS; i++)
			avg[i] = avg_q[i];
	end

	assign eval    = eval_s3;
	assign pending = (valid_s1 && rend_s1) || (wr_s2 && rend_s2) || eval_s3;

endmodule

>>> rtl/core/fgtt_match.sv
// Window compare in priority order and track latch.
module fgtt_match import fgtt_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         eval,
	input  fgtt_avg_t [FGTT_FINGERS-1:0] avg,
	input  fgtt_win_t [FGTT_FINGERS-1:0] win,
	output fgtt_play_t                   play
);

	fgtt_track_t             latched_q;
	logic [FGTT_FINGERS-1:0] hit;
	logic                    any, found;
	fgtt_track_t             trk;

	always_comb begin
		for (int k = 0; k < FGTT_FINGERS; k++) begin
			hit[k] = (avg[FGTT_PRIO[k]] >= win[FGTT_PRIO[k]][11:0])
				&& (avg[FGTT_PRIO[k]] <= win[FGTT_PRIO[k]][23:12]);
		end
	end

	always_comb begin
		found = 1'b0;
		trk   = '0;
		for (int k = 0; k < FGTT_FINGERS; k++) begin
			if (hit[k] && !found && latched_q != 3'(k + 1)) begin
				found = 1'b1;
				trk   = 3'(k + 1);
			end
		end
	end

	assign any = |hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
		end else if (eval) begin
			if (found)
				latched_q <= trk;
			else if (!any)
				latched_q <= '0;
		end
	end

	assign play.start = eval && found;
	assign play.track = trk;

endmodule

>>> rtl/core/fgtt_frame.sv
// Play-track frame sequencer: ten words per frame.
module fgtt_frame import fgtt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fgtt_play_t play,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] frame_byte,
	output logic       frame_end
);

	logic        busy_q;
	fgtt_pos_t   pos_q;
	fgtt_track_t track_q;
	logic        out_acc;

	assign out_acc = busy_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (play.start) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (out_acc) begin
			if (pos_q == FGTT_LAST_POS) begin
				busy_q <= 1'b0;
				pos_q  <= '0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (play.start)
			track_q <= play.track;
	end

	assign out_valid  = busy_q;
	assign frame_byte = fgtt_frame_byte(pos_q, track_q);
	assign frame_end  = (pos_q == FGTT_LAST_POS);

endmodule

>>> rtl/core/flex_gesture_track_trigger_unit.sv
// Top level of the flex gesture track trigger.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall   | sample[11:0]
//  out     | from block| out_valid/out_stall | frame_byte[7:0], frame_end
//  cfg     | to block  | cfg_wr_en           | cfg_index[2:0], cfg_data[23:0]
//
// One sample word per cycle while in_stall is low. The round-end word passes the s1, s2, s3
// and busy registers before its first byte shows; a frame is ten words, one per cycle unstalled.
// in_stall rises only on a round-end word while an evaluation or frame is open.
// arst_n clears counters, sum, latch, frame sequencer and windows to defaults.
// Averages have no reset; each is written before it is read in a round.
module flex_gesture_track_trigger_unit import fgtt_pkg::*; #(
	parameter int SAMPLES_PER_FINGER = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [FGTT_SAMPLE_W-1:0]  sample,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                frame_byte,
	output logic                      frame_end,
	input  logic                      cfg_wr_en,
	input  logic [FGTT_REG_IDX_W-1:0] cfg_index,
	input  logic [FGTT_WIN_W-1:0]     cfg_data
);

	fgtt_win_t [FGTT_FINGERS-1:0] win_q;
	fgtt_avg_t [FGTT_FINGERS-1:0] avg;
	logic                         in_acc, eval, pending, next_rend;
	fgtt_play_t                   play;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FGTT_FINGERS; i++)
				win_q[i] <= FGTT_WIN_RESET[i];
		end else if (cfg_wr_en && cfg_index <= FGTT_REG_PINKY) begin
			win_q[cfg_index] <= cfg_data;
		end
	end

	assign in_stall = next_rend && (pending || out_valid);
	assign in_acc   = in_valid && !in_stall;

	fgtt_average #(
		.SAMPLES (SAMPLES_PER_FINGER)
	) u_average (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.sample    (sample),
		.avg       (avg),
		.eval      (eval),
		.pending   (pending),
		.next_rend (next_rend)
	);

	fgtt_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.eval   (eval),
		.avg    (avg),
		.win    (win_q),
		.play   (play)
	);

	fgtt_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.play       (play),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

endmodule

>>> rtl/core/fgtt_checker.sv
// Port-level checks of the gesture track trigger, bound to the top level.
`include "flex_gesture_track_trigger_unit_assert.svh"

module fgtt_checker import fgtt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       frame_end
);

	`FGTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({frame_byte, frame_end}))
	`FGTT_ASSERT_IMPL(a_end_byte, out_valid && frame_end, frame_byte == FGTT_END_BYTE)
	`FGTT_ASSERT_NEXT(a_gap_after_end, out_valid && !out_stall && frame_end, !out_valid)
	`FGTT_ASSERT_IMPL(a_start_byte, $rose(out_valid), frame_byte == FGTT_START_BYTE)
	`FGTT_ASSERT_NEXT(a_hold_to_end, out_valid && !frame_end, out_valid)

endmodule

bind flex_gesture_track_trigger_unit fgtt_checker u_fgtt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.frame_end  (frame_end)
);
